@@ rtl/bigt_pkg.sv @@
// ----------------------------------------------------------------------------
// bigt_pkg
// shared types and constants for the block ID gap tracker
// ----------------------------------------------------------------------------
package bigt_pkg;

    localparam int ID_W   = 64;
    localparam int CNT_W  = 64;
    localparam int MODE_W = 2;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [MODE_W-1:0] MODE_AUTO = 2'd0;
    localparam logic [MODE_W-1:0] MODE_16   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_64   = 2'd2;

    localparam logic [15:0] ID_MAX16  = 16'hFFFF;
    localparam logic [15:0] ID_HALF16 = 16'h7FFF;

    // register index of id_mode in the config space
    localparam logic REG_ID_MODE = 1'b0;

    typedef struct packed {
        logic pre_bad;
        logic sixteen;
    } t_cls;

    typedef struct packed {
        logic [ID_W-1:0] pkt_id;
        t_cls            cls;
    } t_item;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic             anomaly;
        logic [ID_W-1:0]  gap_size;
        logic [ID_W-1:0]  first_missing_id;
        logic [CNT_W-1:0] observed_count;
        logic [CNT_W-1:0] anomaly_count;
        logic [CNT_W-1:0] missed_total;
    } t_res;

endpackage

@@ rtl/bigt_if.sv @@
// ----------------------------------------------------------------------------
// bigt_if
// valid/ready channels for block IDs and tracker results
// ----------------------------------------------------------------------------
interface bigt_id_if;
    logic                      valid;
    logic                      ready;
    logic [bigt_pkg::ID_W-1:0] pkt_id;

    modport source (output valid, output pkt_id, input ready);
    modport sink   (input valid, input pkt_id, output ready);
endinterface

interface bigt_res_if;
    logic                       valid;
    logic                       ready;
    logic                       anomaly;
    logic [bigt_pkg::ID_W-1:0]  gap_size;
    logic [bigt_pkg::ID_W-1:0]  first_missing_id;
    logic [bigt_pkg::CNT_W-1:0] observed_count;
    logic [bigt_pkg::CNT_W-1:0] anomaly_count;
    logic [bigt_pkg::CNT_W-1:0] missed_total;

    modport source (output valid, output anomaly, output gap_size, output first_missing_id,
                    output observed_count, output anomaly_count, output missed_total,
                    input ready);
    modport sink   (input valid, input anomaly, input gap_size, input first_missing_id,
                    input observed_count, input anomaly_count, input missed_total,
                    output ready);
endinterface

@@ rtl/bigt_front.sv @@
// ----------------------------------------------------------------------------
// bigt_front
// accepts block IDs, tracks wide IDs and classifies each request
// ----------------------------------------------------------------------------
module bigt_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    bigt_id_if.sink                     i_id,
    input  logic [bigt_pkg::MODE_W-1:0] i_mode,
    input  bigt_pkg::t_q_stat           i_q_stat,
    output logic                        o_push,
    output bigt_pkg::t_item             o_item
);

    logic r_wide_seen;
    logic n_wide_seen;
    logic id_wide;

    assign i_id.ready = !i_q_stat.full;
    assign o_push     = i_id.valid && i_id.ready;

    always_comb begin
        id_wide     = i_id.pkt_id > bigt_pkg::ID_W'(bigt_pkg::ID_MAX16);
        n_wide_seen = r_wide_seen || id_wide;

        o_item.pkt_id      = i_id.pkt_id;
        o_item.cls.pre_bad = (i_id.pkt_id == '0) ||
                             ((i_mode == bigt_pkg::MODE_16) && id_wide);
        // auto mode stays 16-bit until a wide ID shows up, this one included
        o_item.cls.sixteen = (i_mode == bigt_pkg::MODE_16) ||
                             ((i_mode == bigt_pkg::MODE_AUTO) && !n_wide_seen);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wide_seen <= 1'b0;
        end else if (o_push) begin
            r_wide_seen <= n_wide_seen;
        end
    end

endmodule

@@ rtl/bigt_queue.sv @@
// ----------------------------------------------------------------------------
// bigt_queue
// short fifo between the classifying front and the tracking back end
// ----------------------------------------------------------------------------
module bigt_queue #(
    parameter int DEPTH = bigt_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  bigt_pkg::t_item   i_item,
    input  logic              i_pop,
    output bigt_pkg::t_item   o_head,
    output bigt_pkg::t_q_stat o_stat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bigt_pkg::t_item  r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_cnt == '0);
    assign o_stat.full  = (r_cnt == CNT_W'(DEPTH));

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        n_cnt = r_cnt + CNT_W'(i_push) - CNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ rtl/bigt_back.sv @@
// ----------------------------------------------------------------------------
// bigt_back
// judges each classified ID against the baseline, keeps the counters
// and holds the result in an output register
// ----------------------------------------------------------------------------
module bigt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  bigt_pkg::t_item   i_head,
    input  bigt_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    bigt_res_if.source        o_res
);

    logic                       r_awaiting;
    logic [bigt_pkg::ID_W-1:0]  r_last, n_last;
    logic [bigt_pkg::CNT_W-1:0] r_seen, n_seen;
    logic [bigt_pkg::CNT_W-1:0] r_anom, n_anom;
    logic [bigt_pkg::CNT_W-1:0] r_missed, n_missed;
    logic                       r_out_valid;
    bigt_pkg::t_res             r_res, n_res;

    logic [15:0]               expect16;
    logic [16:0]               wrap_sum;
    logic [15:0]               dist16;
    logic [bigt_pkg::ID_W-1:0] gap64;
    logic                      bad;
    logic                      take_new;
    logic [bigt_pkg::ID_W-1:0] gap;
    logic [bigt_pkg::ID_W-1:0] fmiss;

    assign o_pop = !i_q_stat.empty && (!r_out_valid || o_res.ready);

    always_comb begin
        // 16-bit cycle skips 0, a baseline at or above the top wraps to 1
        expect16 = (r_last >= bigt_pkg::ID_W'(bigt_pkg::ID_MAX16)) ? 16'd1
                                                                    : r_last[15:0] + 16'd1;
        wrap_sum = {1'b0, i_head.pkt_id[15:0]} + {1'b0, bigt_pkg::ID_MAX16}
                   - {1'b0, expect16};
        dist16   = (wrap_sum >= {1'b0, bigt_pkg::ID_MAX16})
                   ? 16'(wrap_sum - {1'b0, bigt_pkg::ID_MAX16}) : wrap_sum[15:0];
        // id - last - 1
        gap64    = i_head.pkt_id + ~r_last;

        bad      = 1'b0;
        take_new = 1'b0;
        gap      = '0;
        fmiss    = '0;
        n_missed = r_missed;
        if (i_head.cls.pre_bad) begin
            bad = 1'b1;
        end else if (r_awaiting) begin
            take_new = 1'b1;
        end else if (i_head.cls.sixteen) begin
            if (dist16 > bigt_pkg::ID_HALF16) begin
                bad = 1'b1;
            end else begin
                take_new = 1'b1;
                gap      = bigt_pkg::ID_W'(dist16);
                fmiss    = (dist16 != '0) ? bigt_pkg::ID_W'(expect16) : '0;
                n_missed = r_missed + bigt_pkg::CNT_W'(dist16);
            end
        end else if (i_head.pkt_id <= r_last) begin
            bad = 1'b1;
        end else begin
            take_new = 1'b1;
            gap      = gap64;
            fmiss    = (gap64 != '0) ? r_last + bigt_pkg::ID_W'(1) : '0;
            n_missed = r_missed + i_head.pkt_id + ~r_last;
        end

        n_last = take_new ? i_head.pkt_id : r_last;
        n_seen = r_seen + bigt_pkg::CNT_W'(1);
        n_anom = r_anom + bigt_pkg::CNT_W'(bad);

        n_res.anomaly          = bad;
        n_res.gap_size         = gap;
        n_res.first_missing_id = fmiss;
        n_res.observed_count   = n_seen;
        n_res.anomaly_count    = n_anom;
        n_res.missed_total     = n_missed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting  <= 1'b1;
            r_last      <= '0;
            r_seen      <= '0;
            r_anom      <= '0;
            r_missed    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_awaiting  <= r_awaiting && !take_new;
                r_last      <= n_last;
                r_seen      <= n_seen;
                r_anom      <= n_anom;
                r_missed    <= n_missed;
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.anomaly          = r_res.anomaly;
    assign o_res.gap_size         = r_res.gap_size;
    assign o_res.first_missing_id = r_res.first_missing_id;
    assign o_res.observed_count   = r_res.observed_count;
    assign o_res.anomaly_count    = r_res.anomaly_count;
    assign o_res.missed_total     = r_res.missed_total;

endmodule

@@ rtl/block_id_gap_tracker.sv @@
// ----------------------------------------------------------------------------
// block_id_gap_tracker
// continuity checker for packet block IDs with gap and anomaly counters
// ----------------------------------------------------------------------------
// Takes one block ID per cycle and returns one result per ID, in order. A
// result passes through the queue and then the output register before it is
// valid. Sustained rate is one ID per clock while the result sink is ready,
// set by the back end's update of the baseline and counters (one 64-bit
// compare and add on the last forward ID). The front end classifies IDs
// against the mode and the wide-ID flag, a small queue (QUEUE_DEPTH entries)
// decouples it from the back end, and the output register holds a result while
// the sink stalls; once the queue fills, input ready drops until the back end
// pops again. id_mode lives at byte address 0 of the APB port; the user is to
// have it written only while the tracker is idle; the block does not check.
module block_id_gap_tracker #(
    parameter int QUEUE_DEPTH = bigt_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bigt_id_if.sink     i_id,
    bigt_res_if.source  o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [bigt_pkg::MODE_W-1:0] r_mode;
    logic                        cfg_wr;
    logic                        push;
    logic                        pop;
    bigt_pkg::t_item             item;
    bigt_pkg::t_item             head;
    bigt_pkg::t_q_stat           q_stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == bigt_pkg::REG_ID_MODE);
    assign prdata = (paddr[2] == bigt_pkg::REG_ID_MODE) ? {30'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bigt_pkg::MODE_AUTO;
        end else if (cfg_wr) begin
            r_mode <= pwdata[bigt_pkg::MODE_W-1:0];
        end
    end

    bigt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_id     (i_id),
        .i_mode   (r_mode),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_item   (item)
    );

    bigt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    bigt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_res    (o_res)
    );

    // an accepted request is waiting in the queue on the next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_id.valid && i_id.ready) |=> !q_stat.empty)
        else $error("accepted block ID missing from queue");

    a_anomaly_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.anomaly) |-> (o_res.gap_size == '0 && o_res.first_missing_id == '0))
        else $error("anomalous result carries a gap");

    a_gap_has_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.gap_size != '0) |-> (o_res.first_missing_id != '0))
        else $error("gap reported without first missing ID");

    a_pop_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |=> o_res.valid)
        else $error("popped item did not reach the output register");

endmodule

@@ sim/bigt_continuity_checker.sv @@
// ----------------------------------------------------------------------------
// bigt_continuity_checker
// watches the block ID and result channels and the register port, predicts
// the verdict for every accepted block ID and compares results in order
// ----------------------------------------------------------------------------
module bigt_continuity_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bigt_id_if          id_ch,
    bigt_res_if         res_ch,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic        i_pready,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    output int          o_mismatches,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]                ADDR_ID_MODE = {bigt_pkg::REG_ID_MODE, 2'b00};
    localparam logic [bigt_pkg::ID_W-1:0] ID_LIMIT16   = {48'd0, bigt_pkg::ID_MAX16};
    localparam logic [bigt_pkg::ID_W-1:0] ID_WINDOW16  = {48'd0, bigt_pkg::ID_HALF16};

    logic [bigt_pkg::MODE_W-1:0] cur_mode;
    logic                        seed_pending;
    logic                        wide_flag;
    logic [bigt_pkg::ID_W-1:0]   last_fwd;
    logic [bigt_pkg::CNT_W-1:0]  seen_cnt;
    logic [bigt_pkg::CNT_W-1:0]  anom_cnt;
    logic [bigt_pkg::CNT_W-1:0]  miss_cnt;
    bigt_pkg::t_res              predicted_verdicts[$];
    int                          mismatch_count = 0;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= 100) begin
            $display("tb: mismatch on %s at %0t: got %h, want %h", what, $realtime, got, want);
        end
    endtask

    // verdict for one block ID, updating the tracked baseline and counters
    task automatic judge_pkt_id(input logic [bigt_pkg::ID_W-1:0] id,
                                output bigt_pkg::t_res verdict);
        logic [bigt_pkg::ID_W-1:0] next_id;
        logic [bigt_pkg::ID_W-1:0] span;
        logic                      bad;
        logic                      narrow;
        verdict  = '0;
        bad      = 1'b0;
        seen_cnt = seen_cnt + 64'd1;
        if (id > ID_LIMIT16) begin
            wide_flag = 1'b1;
        end
        if (id == '0 || (cur_mode == bigt_pkg::MODE_16 && id > ID_LIMIT16)) begin
            bad = 1'b1;
        end else if (seed_pending) begin
            seed_pending = 1'b0;
            last_fwd     = id;
        end else begin
            narrow = (cur_mode == bigt_pkg::MODE_16) ||
                     (cur_mode == bigt_pkg::MODE_AUTO && !wide_flag);
            if (narrow) begin
                // wrapping ids skip zero, so the cycle length is 0xffff
                next_id = (last_fwd >= ID_LIMIT16) ? 64'd1 : last_fwd + 64'd1;
                if (id > ID_LIMIT16) begin
                    bad = 1'b1;
                end else if (id == next_id) begin
                    last_fwd = id;
                end else begin
                    span = (id + ID_LIMIT16 - next_id) % ID_LIMIT16;
                    if (span == '0 || span > ID_WINDOW16) begin
                        bad = 1'b1;
                    end else begin
                        verdict.gap_size         = span;
                        verdict.first_missing_id = next_id;
                        miss_cnt                 = miss_cnt + span;
                        last_fwd                 = id;
                    end
                end
            end else if (id <= last_fwd) begin
                bad = 1'b1;
            end else begin
                verdict.gap_size = id - last_fwd - 64'd1;
                if (verdict.gap_size != '0) begin
                    verdict.first_missing_id = last_fwd + 64'd1;
                end
                miss_cnt = miss_cnt + verdict.gap_size;
                last_fwd = id;
            end
        end
        if (bad) begin
            anom_cnt = anom_cnt + 64'd1;
        end
        verdict.anomaly        = bad;
        verdict.observed_count = seen_cnt;
        verdict.anomaly_count  = anom_cnt;
        verdict.missed_total   = miss_cnt;
    endtask

    always @(posedge i_clk) begin
        bigt_pkg::t_res want;
        bigt_pkg::t_res got;
        if (!i_rst_n) begin
            cur_mode     = bigt_pkg::MODE_AUTO;
            seed_pending = 1'b1;
            wide_flag    = 1'b0;
            last_fwd     = '0;
            seen_cnt     = '0;
            anom_cnt     = '0;
            miss_cnt     = '0;
            predicted_verdicts.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_ID_MODE) begin
                cur_mode = i_pwdata[bigt_pkg::MODE_W-1:0];
            end
            if (id_ch.valid && id_ch.ready) begin
                judge_pkt_id(id_ch.pkt_id, want);
                predicted_verdicts.push_back(want);
            end
            if (res_ch.valid && res_ch.ready) begin
                got.anomaly          = res_ch.anomaly;
                got.gap_size         = res_ch.gap_size;
                got.first_missing_id = res_ch.first_missing_id;
                got.observed_count   = res_ch.observed_count;
                got.anomaly_count    = res_ch.anomaly_count;
                got.missed_total     = res_ch.missed_total;
                if (predicted_verdicts.size() == 0) begin
                    report_mismatch("unrequested result", got.observed_count, '0);
                end else begin
                    want = predicted_verdicts.pop_front();
                    if (got.anomaly != want.anomaly)
                        report_mismatch("anomaly", 64'(got.anomaly), 64'(want.anomaly));
                    if (got.gap_size != want.gap_size)
                        report_mismatch("gap_size", got.gap_size, want.gap_size);
                    if (got.first_missing_id != want.first_missing_id)
                        report_mismatch("first_missing_id", got.first_missing_id,
                                        want.first_missing_id);
                    if (got.observed_count != want.observed_count)
                        report_mismatch("observed_count", got.observed_count,
                                        want.observed_count);
                    if (got.anomaly_count != want.anomaly_count)
                        report_mismatch("anomaly_count", got.anomaly_count,
                                        want.anomaly_count);
                    if (got.missed_total != want.missed_total)
                        report_mismatch("missed_total", got.missed_total, want.missed_total);
                end
            end
        end
        o_outstanding <= predicted_verdicts.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

@@ sim/tb_block_id_gap_tracker.sv @@
// ----------------------------------------------------------------------------
// tb_block_id_gap_tracker
// drives block ID requests and mode writes into the gap tracker: directed
// wrap, gap, duplicate and mode-change cases, then random runs of mostly
// in-order IDs per mode with noise, random stalls on both channels
// ----------------------------------------------------------------------------
module tb_block_id_gap_tracker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0]                  ADDR_ID_MODE = {bigt_pkg::REG_ID_MODE, 2'b00};
    localparam logic [bigt_pkg::ID_W-1:0]   ID_LIMIT16   = {48'd0, bigt_pkg::ID_MAX16};
    localparam logic [bigt_pkg::ID_W-1:0]   ID_WINDOW16  = {48'd0, bigt_pkg::ID_HALF16};
    localparam logic [bigt_pkg::ID_W-1:0]   ID_TOP       = {bigt_pkg::ID_W{1'b1}};
    localparam logic [bigt_pkg::MODE_W-1:0] MODE_SPARE   = 2'd3;
    localparam int                          DRAIN_LIMIT  = 5000;
    localparam int                          PHASE_LEN    = 45;
    localparam logic [bigt_pkg::MODE_W-1:0] PHASE_MODES [8] = '{
        bigt_pkg::MODE_64, bigt_pkg::MODE_AUTO, bigt_pkg::MODE_16, MODE_SPARE,
        bigt_pkg::MODE_16, bigt_pkg::MODE_64, bigt_pkg::MODE_AUTO, bigt_pkg::MODE_16};

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        id_valid  = 1'b0;
    logic [63:0] id_data   = '0;
    logic        res_ready = 1'b0;
    logic        apb_sel   = 1'b0;
    logic        apb_en    = 1'b0;
    logic        apb_wr    = 1'b0;
    logic [2:0]  apb_addr  = '0;
    logic [31:0] apb_wdata = '0;
    logic [31:0] apb_rdata;
    logic        apb_ready;
    int          mismatches;
    int          outstanding;

    // stimulus-side view of the baseline, kept in step with well-formed ids
    logic [bigt_pkg::ID_W-1:0]   gen_last;
    logic                        wide_sent = 1'b0;
    logic [bigt_pkg::MODE_W-1:0] cur_mode  = bigt_pkg::MODE_AUTO;
    bit                          send_calm = 1'b0;
    bit                          res_calm  = 1'b0;
    int                          res_hold  = 0;

    bigt_id_if  id_ch ();
    bigt_res_if res_ch ();

    assign id_ch.valid  = id_valid;
    assign id_ch.pkt_id = id_data;
    assign res_ch.ready = res_ready;

    block_id_gap_tracker u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_id    (id_ch),
        .o_res   (res_ch),
        .psel    (apb_sel),
        .penable (apb_en),
        .pwrite  (apb_wr),
        .paddr   (apb_addr),
        .pwdata  (apb_wdata),
        .prdata  (apb_rdata),
        .pready  (apb_ready)
    );

    bigt_continuity_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .id_ch         (id_ch),
        .res_ch        (res_ch),
        .i_psel        (apb_sel),
        .i_penable     (apb_en),
        .i_pwrite      (apb_wr),
        .i_pready      (apb_ready),
        .i_paddr       (apb_addr),
        .i_pwdata      (apb_wdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("tb: failure");
        $finish;
    end

    function automatic int idle_len(input bit calm);
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [bigt_pkg::ID_W-1:0] narrow_next(
        input logic [bigt_pkg::ID_W-1:0] last);
        return (last >= ID_LIMIT16) ? 64'd1 : last + 64'd1;
    endfunction

    // id that lies span steps past next_id on the 1..0xffff cycle
    function automatic logic [bigt_pkg::ID_W-1:0] narrow_wrap(
        input logic [bigt_pkg::ID_W-1:0] next_id,
        input logic [bigt_pkg::ID_W-1:0] span);
        return ((next_id - 64'd1 + span) % ID_LIMIT16) + 64'd1;
    endfunction

    // result sink: random stalls with calm stretches
    always @(posedge i_clk) begin
        if (res_hold > 0) begin
            res_ready <= 1'b0;
            res_hold = res_hold - 1;
        end else begin
            res_ready <= 1'b1;
            if ($urandom_range(0, 49) == 0) res_calm = !res_calm;
            res_hold = idle_len(res_calm);
        end
    end

    task automatic send_id(input logic [bigt_pkg::ID_W-1:0] id);
        int pause;
        id_valid <= 1'b1;
        id_data  <= id;
        if (id > ID_LIMIT16) wide_sent = 1'b1;
        do @(posedge i_clk); while (!id_ch.ready);
        if ($urandom_range(0, 49) == 0) send_calm = !send_calm;
        pause = idle_len(send_calm);
        if (pause > 0) begin
            id_valid <= 1'b0;
            repeat (pause) @(posedge i_clk);
        end
    endtask

    // hold off requests until every predicted result has come back
    task automatic drain();
        int guard;
        id_valid <= 1'b0;
        @(posedge i_clk);
        guard = 0;
        while (outstanding != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_mode(input logic [bigt_pkg::MODE_W-1:0] mode);
        drain();
        apb_sel   <= 1'b1;
        apb_en    <= 1'b0;
        apb_wr    <= 1'b1;
        apb_addr  <= ADDR_ID_MODE;
        apb_wdata <= {{(32-bigt_pkg::MODE_W){1'b0}}, mode};
        @(posedge i_clk);
        apb_en <= 1'b1;
        do @(posedge i_clk); while (!apb_ready);
        apb_sel <= 1'b0;
        apb_en  <= 1'b0;
        apb_wr  <= 1'b0;
        cur_mode = mode;
        @(posedge i_clk);
    endtask

    task automatic send_narrow(input bit allow_wide);
        logic [bigt_pkg::ID_W-1:0] next_id;
        logic [bigt_pkg::ID_W-1:0] span;
        logic [bigt_pkg::ID_W-1:0] id;
        int                        r;
        int                        pick;
        next_id = narrow_next(gen_last);
        r = $urandom_range(0, 99);
        if (r < 85) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      span = '0;
            else if (pick < 85) span = 64'($urandom_range(1, 20));
            else if (pick < 97) span = 64'($urandom_range(21, 32766));
            else                span = ID_WINDOW16;
            id       = narrow_wrap(next_id, span);
            gen_last = id;
        end else if (r < 92) begin
            // backward or duplicate: distance past the half window
            id = narrow_wrap(next_id, 64'($urandom_range(32768, 65534)));
        end else if (r < 96 || !allow_wide) begin
            id = '0;
        end else begin
            id = {$urandom, $urandom} | 64'h1_0000;
        end
        send_id(id);
    endtask

    task automatic send_wide64();
        logic [bigt_pkg::ID_W-1:0] id;
        logic [bigt_pkg::ID_W-1:0] gap;
        logic [bigt_pkg::ID_W-1:0] room;
        int                        r;
        int                        pick;
        room = ID_TOP - gen_last;
        r = $urandom_range(0, 99);
        if (r < 85 && room != '0) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)      gap = '0;
            else if (pick < 85) gap = 64'($urandom_range(1, 100));
            else                gap = {$urandom, $urandom} >> $urandom_range(0, 63);
            if (gap >= room) gap = room >> 1;
            id       = gen_last + gap + 64'd1;
            gen_last = id;
        end else begin
            pick = $urandom_range(0, 3);
            case (pick)
                0: id = gen_last;
                1: id = gen_last >> $urandom_range(0, 63);
                2: id = '0;
                default: begin
                    id = {$urandom, $urandom};
                    if (id > gen_last) gen_last = id;
                end
            endcase
        end
        send_id(id);
    endtask

    task automatic send_item();
        if (cur_mode == bigt_pkg::MODE_16 ||
            (cur_mode == bigt_pkg::MODE_AUTO && !wide_sent)) begin
            send_narrow(cur_mode == bigt_pkg::MODE_16);
        end else begin
            send_wide64();
        end
    endtask

    task automatic run_items(input int count);
        repeat (count) begin
            if ($urandom_range(0, 99) == 0) drain();
            send_item();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // auto mode before any wide id: wrapping 16-bit behavior
        send_id(64'd0);        // invalid first id, no baseline
        send_id(64'd5);        // seeds the baseline
        send_id(64'd6);
        send_id(64'd6);        // duplicate
        send_id(64'd3);        // backward
        send_id(64'd10);       // gap of three
        send_id(64'h800A);     // largest forward gap
        send_id(64'hFFFF);
        send_id(64'd1);        // wrap skips zero
        send_id(64'h8002);     // just past the half window
        send_id(64'h8000);
        send_id(64'hFFFE);
        send_id(64'd3);        // gap across the wrap
        gen_last = 64'd3;
        run_items(40);

        write_mode(bigt_pkg::MODE_16);
        send_id(ID_TOP);           // wide id in forced 16-bit mode
        send_id(64'h1_0000);
        gen_last = narrow_next(gen_last);
        send_id(gen_last);

        // auto mode after a wide id runs as 64-bit
        write_mode(bigt_pkg::MODE_AUTO);
        send_id(gen_last + 64'd1);
        send_id(64'h8000_0000_0000_0000);
        send_id(64'h8000_0000_0000_0000);
        write_mode(bigt_pkg::MODE_64);
        send_id(64'h7FFF_FFFF_FFFF_FFFF);
        send_id(64'hC000_0000_0000_0001);
        write_mode(MODE_SPARE);
        send_id(64'hC000_0000_0000_0002);
        send_id(ID_TOP);
        // baseline kept across the mode change, expected id is 1
        write_mode(bigt_pkg::MODE_16);
        send_id(64'd1);
        gen_last = 64'd1;

        foreach (PHASE_MODES[p]) begin
            write_mode(PHASE_MODES[p]);
            run_items(PHASE_LEN);
        end

        drain();
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
